[rtl/pzit_pkg.sv]
// ----------------------------------------------------------------------------
// pzit_pkg
// Shared constants, codes and types of the proximity zone interaction tracker.
// ----------------------------------------------------------------------------
package pzit_pkg;

   localparam int DIST_W        = 16;
   localparam int ZONE_W        = 2;
   localparam int CSR_IDX_W     = 2;
   localparam int SLOTS         = 4;
   localparam int KEPT_DEPTH_DEF = 4;
   localparam int QUEUE_DEPTH_DEF = 2;

   localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

   localparam logic [DIST_W-1:0] NEAR_RESET  = 16'd24;
   localparam logic [DIST_W-1:0] FAR_RESET   = 16'd72;
   localparam logic [DIST_W-1:0] RANGE_RESET = 16'd200;

   localparam logic [ZONE_W-1:0] ZONE_CLOSE = 2'd0;
   localparam logic [ZONE_W-1:0] ZONE_RIGHT = 2'd1;
   localparam logic [ZONE_W-1:0] ZONE_FAR   = 2'd2;
   localparam logic [ZONE_W-1:0] ZONE_OUT   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_NEAR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE = 2'd2;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [ZONE_W-1:0] zone;
   } item_type;

   typedef struct packed {
      logic [DIST_W-1:0]            echo_distance;
      logic [ZONE_W-1:0]            zone;
      logic                         engaged;
      logic                         unsafe_now;
      logic [DIST_W-1:0]            total_events;
      logic [DIST_W-1:0]            unsafe_events;
      logic [DIST_W-1:0]            nearest_seen;
      logic [SLOTS-1:0][DIST_W-1:0] kept;
   } result_type;

   typedef struct packed {
      logic item_valid;
      logic result_ready;
   } back_ctl_type;

endpackage

[rtl/proximity_zone_interaction_tracker_top.sv]
// ----------------------------------------------------------------------------
// proximity_zone_interaction_tracker_top
// Zone classifier and interaction tracker for a stream of distance samples.
// ----------------------------------------------------------------------------
// Takes one distance word per cycle while req_full is low and returns one
// result word per accepted sample, in order. A pushed sample is classified
// against the threshold registers and written into the mid queue; the
// tracking stage folds it into the interaction state and queues the result
// once the output queue has room, and it shows on the rsp_ ports. The
// sustained rate is one word per cycle while results are popped; each side
// has a two-word queue, so a stalled reader still leaves room for two more
// samples. Threshold writes take effect at the next edge and belong between
// bursts, once all results have been popped.
module proximity_zone_interaction_tracker_top #(
   parameter int KEPT_DEPTH  = pzit_pkg::KEPT_DEPTH_DEF,
   parameter int QUEUE_DEPTH = pzit_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [pzit_pkg::DIST_W-1:0]     req_distance,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [pzit_pkg::DIST_W-1:0]     rsp_echo_distance,
   output logic [pzit_pkg::ZONE_W-1:0]     rsp_zone,
   output logic                            rsp_engaged,
   output logic                            rsp_unsafe_now,
   output logic [pzit_pkg::DIST_W-1:0]     rsp_total_events,
   output logic [pzit_pkg::DIST_W-1:0]     rsp_unsafe_events,
   output logic [pzit_pkg::DIST_W-1:0]     rsp_nearest_seen,
   output logic [pzit_pkg::DIST_W-1:0]     rsp_kept_first,
   output logic [pzit_pkg::DIST_W-1:0]     rsp_kept_second,
   output logic [pzit_pkg::DIST_W-1:0]     rsp_kept_third,
   output logic [pzit_pkg::DIST_W-1:0]     rsp_kept_fourth,
   input  logic                            csr_write_en,
   input  logic [pzit_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pzit_pkg::DIST_W-1:0]     csr_data
);

   localparam int ITEM_W   = $bits(pzit_pkg::item_type);
   localparam int RESULT_W = $bits(pzit_pkg::result_type);

   pzit_pkg::item_type     front_item;
   pzit_pkg::item_type     mid_head;
   pzit_pkg::result_type   back_result;
   pzit_pkg::result_type   out_head;
   pzit_pkg::back_ctl_type back_ctl;
   logic [ITEM_W-1:0]      mid_pop_data;
   logic [RESULT_W-1:0]    out_pop_data;
   logic                   mid_empty;
   logic                   out_full;
   logic                   back_take;

   pzit_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .distance     (req_distance),
      .item         (front_item)
   );

   pzit_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_item),
      .full      (req_full),
      .pop       (back_take),
      .pop_data  (mid_pop_data),
      .empty     (mid_empty)
   );

   assign mid_head              = pzit_pkg::item_type'(mid_pop_data);
   assign back_ctl.item_valid   = !mid_empty;
   assign back_ctl.result_ready = !out_full;

   pzit_back #(
      .KEPT_DEPTH (KEPT_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ctl       (back_ctl),
      .item      (mid_head),
      .item_take (back_take),
      .result    (back_result)
   );

   pzit_queue #(
      .WIDTH (RESULT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_take),
      .push_data (back_result),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_pop_data),
      .empty     (rsp_empty)
   );

   assign out_head          = pzit_pkg::result_type'(out_pop_data);
   assign rsp_echo_distance = out_head.echo_distance;
   assign rsp_zone          = out_head.zone;
   assign rsp_engaged       = out_head.engaged;
   assign rsp_unsafe_now    = out_head.unsafe_now;
   assign rsp_total_events  = out_head.total_events;
   assign rsp_unsafe_events = out_head.unsafe_events;
   assign rsp_nearest_seen  = out_head.nearest_seen;
   assign rsp_kept_first    = out_head.kept[0];
   assign rsp_kept_second   = out_head.kept[1];
   assign rsp_kept_third    = out_head.kept[2];
   assign rsp_kept_fourth   = out_head.kept[3];

endmodule

[rtl/pzit_queue.sv]
// ----------------------------------------------------------------------------
// pzit_queue
// Small first-in first-out queue of fixed-width words.
// ----------------------------------------------------------------------------
module pzit_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = pzit_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/pzit_front.sv]
// ----------------------------------------------------------------------------
// pzit_front
// Threshold registers and zone classification of incoming distance words.
// ----------------------------------------------------------------------------
module pzit_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [pzit_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pzit_pkg::DIST_W-1:0]      csr_data,
   input  logic [pzit_pkg::DIST_W-1:0]      distance,
   output pzit_pkg::item_type               item
);

   logic [pzit_pkg::DIST_W-1:0] near_ff;
   logic [pzit_pkg::DIST_W-1:0] far_ff;
   logic [pzit_pkg::DIST_W-1:0] range_ff;
   logic [pzit_pkg::ZONE_W-1:0] zone;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff  <= pzit_pkg::NEAR_RESET;
         far_ff   <= pzit_pkg::FAR_RESET;
         range_ff <= pzit_pkg::RANGE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            pzit_pkg::CSR_NEAR:  near_ff  <= csr_data;
            pzit_pkg::CSR_FAR:   far_ff   <= csr_data;
            pzit_pkg::CSR_RANGE: range_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // fixed test order, so thresholds need not ascend
   always_comb begin
      if (distance >= range_ff) begin
         zone = pzit_pkg::ZONE_OUT;
      end else if (distance >= far_ff) begin
         zone = pzit_pkg::ZONE_FAR;
      end else if (distance >= near_ff) begin
         zone = pzit_pkg::ZONE_RIGHT;
      end else begin
         zone = pzit_pkg::ZONE_CLOSE;
      end
   end

   assign item.distance = distance;
   assign item.zone     = zone;

endmodule

[rtl/pzit_back.sv]
// ----------------------------------------------------------------------------
// pzit_back
// Interaction state, saturating counters, window minimum and kept list.
// ----------------------------------------------------------------------------
module pzit_back #(
   parameter int KEPT_DEPTH = pzit_pkg::KEPT_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pzit_pkg::back_ctl_type ctl,
   input  pzit_pkg::item_type     item,
   output logic                   item_take,
   output pzit_pkg::result_type   result
);

   localparam int DW = pzit_pkg::DIST_W;

   logic [pzit_pkg::ZONE_W-1:0]            last_zone_ff, last_zone_in;
   logic                                   active_ff, active_in;
   logic                                   unsafe_ff, unsafe_in;
   logic [DW-1:0]                          started_ff, started_in;
   logic [DW-1:0]                          unsafe_cnt_ff, unsafe_cnt_in;
   logic [DW-1:0]                          window_min_ff, window_min_in;
   logic [KEPT_DEPTH-1:0][DW-1:0]          kept_ff, kept_in;
   logic [KEPT_DEPTH-1:0][DW-1:0]          kept_ins;
   logic [pzit_pkg::SLOTS-1:0][DW-1:0]     kept_out;
   logic                                   do_insert;
   logic                                   zone_near;
   logic                                   prev_near;

   assign item_take = ctl.item_valid && ctl.result_ready;

   assign zone_near = (item.zone == pzit_pkg::ZONE_CLOSE) ||
                      (item.zone == pzit_pkg::ZONE_RIGHT);
   assign prev_near = (last_zone_ff == pzit_pkg::ZONE_CLOSE) ||
                      (last_zone_ff == pzit_pkg::ZONE_RIGHT);

   // sorted insert of the window minimum, in before the first larger entry
   always_comb begin
      logic          placed;
      logic [DW-1:0] carry;
      logic [DW-1:0] cur;
      placed = 1'b0;
      carry  = '0;
      for (int i = 0; i < KEPT_DEPTH; i++) begin
         cur = kept_ff[i];
         if (!placed && (window_min_ff < cur)) begin
            kept_ins[i] = window_min_ff;
            placed      = 1'b1;
            carry       = cur;
         end else if (placed) begin
            kept_ins[i] = carry;
            carry       = cur;
         end else begin
            kept_ins[i] = cur;
         end
      end
   end

   always_comb begin
      last_zone_in  = item.zone;
      active_in     = active_ff;
      unsafe_in     = unsafe_ff;
      started_in    = started_ff;
      unsafe_cnt_in = unsafe_cnt_ff;
      window_min_in = window_min_ff;
      do_insert     = 1'b0;
      if (zone_near) begin
         if (!prev_near && !active_ff) begin
            active_in = 1'b1;
            if (started_ff != pzit_pkg::DIST_MAX) begin
               started_in = started_ff + 1'b1;
            end
         end
         if ((item.zone == pzit_pkg::ZONE_CLOSE) && !unsafe_ff) begin
            unsafe_in = 1'b1;
            if (unsafe_cnt_ff != pzit_pkg::DIST_MAX) begin
               unsafe_cnt_in = unsafe_cnt_ff + 1'b1;
            end
         end
      end else if (prev_near && active_ff) begin
         do_insert     = unsafe_ff;
         active_in     = 1'b0;
         last_zone_in  = pzit_pkg::ZONE_OUT;
         window_min_in = pzit_pkg::DIST_MAX;
         unsafe_in     = 1'b0;
      end
      if (item.distance < window_min_in) begin
         window_min_in = item.distance;
      end
      kept_in = do_insert ? kept_ins : kept_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_zone_ff  <= pzit_pkg::ZONE_OUT;
         active_ff     <= 1'b0;
         unsafe_ff     <= 1'b0;
         started_ff    <= '0;
         unsafe_cnt_ff <= '0;
         window_min_ff <= pzit_pkg::DIST_MAX;
         kept_ff       <= {KEPT_DEPTH{pzit_pkg::DIST_MAX}};
      end else if (item_take) begin
         last_zone_ff  <= last_zone_in;
         active_ff     <= active_in;
         unsafe_ff     <= unsafe_in;
         started_ff    <= started_in;
         unsafe_cnt_ff <= unsafe_cnt_in;
         window_min_ff <= window_min_in;
         kept_ff       <= kept_in;
      end
   end

   for (genvar g = 0; g < pzit_pkg::SLOTS; g++) begin : g_kept
      if (g < KEPT_DEPTH) begin : g_live
         assign kept_out[g] = kept_in[g];
      end else begin : g_empty
         assign kept_out[g] = pzit_pkg::DIST_MAX;
      end
   end

   always_comb begin
      result.echo_distance = item.distance;
      result.zone          = item.zone;
      result.engaged       = active_in;
      result.unsafe_now    = unsafe_in;
      result.total_events  = started_in;
      result.unsafe_events = unsafe_cnt_in;
      result.nearest_seen  = window_min_in;
      result.kept          = kept_out;
   end

endmodule

[rtl/pzit_checker.sv]
// ----------------------------------------------------------------------------
// pzit_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module pzit_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_push,
   input logic                            req_full,
   input logic [pzit_pkg::DIST_W-1:0]     req_distance,
   input logic                            rsp_empty,
   input logic                            rsp_pop,
   input logic [pzit_pkg::DIST_W-1:0]     rsp_echo_distance,
   input logic [pzit_pkg::ZONE_W-1:0]     rsp_zone,
   input logic                            rsp_engaged,
   input logic                            rsp_unsafe_now,
   input logic [pzit_pkg::DIST_W-1:0]     rsp_total_events,
   input logic [pzit_pkg::DIST_W-1:0]     rsp_unsafe_events,
   input logic [pzit_pkg::DIST_W-1:0]     rsp_nearest_seen,
   input logic [pzit_pkg::DIST_W-1:0]     rsp_kept_first,
   input logic [pzit_pkg::DIST_W-1:0]     rsp_kept_second,
   input logic [pzit_pkg::DIST_W-1:0]     rsp_kept_third,
   input logic [pzit_pkg::DIST_W-1:0]     rsp_kept_fourth,
   input logic                            csr_write_en,
   input logic [pzit_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [pzit_pkg::DIST_W-1:0]     csr_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result waiting after reset");

   a_word_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_echo_distance) && $stable(rsp_total_events)))
      else $error("unpopped result word changed");

   a_unsafe_engaged: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_unsafe_now) |-> rsp_engaged)
      else $error("unsafe mark outside an interaction");

   a_engaged_zone: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_engaged) |->
         ((rsp_zone == pzit_pkg::ZONE_CLOSE) || (rsp_zone == pzit_pkg::ZONE_RIGHT)))
      else $error("interaction engaged in a far zone");

   a_counts_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_unsafe_events <= rsp_total_events))
      else $error("more unsafe interactions than started ones");

endmodule

bind proximity_zone_interaction_tracker_top pzit_checker u_pzit_checker (.*);
